// File: src/evad_pkg.sv
package evad_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int RMS_W      = 16;
	localparam int THR_W      = 16;
	localparam int BOOST_W    = 8;
	localparam int FRAMES_W   = 16;
	localparam int MINV_W     = 7;
	localparam int REASON_W   = 2;
	localparam int LEVEL_W    = THR_W + BOOST_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_THR     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTINUE_THR  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_BOOST = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_SILENCE   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EARLY_CLOSE   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VOICED    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES    = 4'd7;

	// end reasons
	localparam logic [REASON_W-1:0] END_NONE    = 2'd0;
	localparam logic [REASON_W-1:0] END_SILENCE = 2'd1;
	localparam logic [REASON_W-1:0] END_LOW_ACT = 2'd2;
	localparam logic [REASON_W-1:0] END_MAX_LEN = 2'd3;

	// Q4.4 one
	localparam logic [BOOST_W-1:0] BOOST_UNITY = 8'd16;

	localparam logic [THR_W-1:0]    RST_START_THR    = 16'd1311;
	localparam logic [THR_W-1:0]    RST_CONTINUE_THR = 16'd983;
	localparam logic [BOOST_W-1:0]  RST_BOOST        = 8'd16;
	localparam logic [FRAMES_W-1:0] RST_MIN_SPEECH   = 16'd10;
	localparam logic [FRAMES_W-1:0] RST_END_SILENCE  = 16'd16;
	localparam logic [FRAMES_W-1:0] RST_EARLY_CLOSE  = 16'd40;
	localparam logic [MINV_W-1:0]   RST_MIN_VOICED   = 7'd0;
	localparam logic [FRAMES_W-1:0] RST_MAX_FRAMES   = 16'd600;

	typedef struct packed {
		logic [THR_W-1:0]    start_threshold;
		logic [THR_W-1:0]    continue_threshold;
		logic [BOOST_W-1:0]  playback_boost;
		logic [FRAMES_W-1:0] min_speech_frames;
		logic [FRAMES_W-1:0] end_silence_frames;
		logic [FRAMES_W-1:0] early_close_min_frames;
		logic [MINV_W-1:0]   min_voiced_in_window;
		logic [FRAMES_W-1:0] max_frames;
	} cfg_t;

	typedef struct packed {
		logic [RMS_W-1:0] frame_level;
		logic             win_full;
		logic             playback_active;
	} in_item_t;

	typedef struct packed {
		logic                voice;
		logic                voice_edge;
		logic                recording;
		logic                started;
		logic [REASON_W-1:0] end_reason;
		logic [FRAMES_W-1:0] frames_recorded;
	} result_t;

endpackage

// File: src/evad_cfg_regs.sv
module evad_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data,
	output evad_pkg::cfg_t                  cfg
);
	import evad_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_threshold        <= RST_START_THR;
			cfg_q.continue_threshold     <= RST_CONTINUE_THR;
			cfg_q.playback_boost         <= RST_BOOST;
			cfg_q.min_speech_frames      <= RST_MIN_SPEECH;
			cfg_q.end_silence_frames     <= RST_END_SILENCE;
			cfg_q.early_close_min_frames <= RST_EARLY_CLOSE;
			cfg_q.min_voiced_in_window   <= RST_MIN_VOICED;
			cfg_q.max_frames             <= RST_MAX_FRAMES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_THR:      cfg_q.start_threshold        <= cfg_data;
				REG_CONTINUE_THR:   cfg_q.continue_threshold     <= cfg_data;
				REG_PLAYBACK_BOOST: cfg_q.playback_boost         <= cfg_data[BOOST_W-1:0];
				REG_MIN_SPEECH:     cfg_q.min_speech_frames      <= cfg_data;
				REG_END_SILENCE:    cfg_q.end_silence_frames     <= cfg_data;
				REG_EARLY_CLOSE:    cfg_q.early_close_min_frames <= cfg_data;
				REG_MIN_VOICED:     cfg_q.min_voiced_in_window   <= cfg_data[MINV_W-1:0];
				REG_MAX_FRAMES:     cfg_q.max_frames             <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: src/evad_endpoint.sv
module evad_endpoint #(
	parameter int WINDOW_FRAMES = 64,
	parameter int COUNT_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  evad_pkg::cfg_t     cfg,
	input  evad_pkg::in_item_t item,
	output evad_pkg::result_t  res
);
	import evad_pkg::*;

	localparam int SUM_W  = $clog2(WINDOW_FRAMES + 1);
	localparam int CMP_W  = (COUNT_BITS > FRAMES_W) ? COUNT_BITS : FRAMES_W;
	localparam int VCMP_W = (SUM_W > MINV_W) ? SUM_W : MINV_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]      PUSH_FULL = SUM_W'(WINDOW_FRAMES);
	localparam logic [FRAMES_W-1:0]   SHOW_MAX  = '1;

	logic                     rec_q;
	logic                     last_q;
	logic [COUNT_BITS-1:0]    fc_q;
	logic [COUNT_BITS-1:0]    sc_q;
	logic [WINDOW_FRAMES-1:0] ring_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         pcnt_q;

	logic [THR_W-1:0]         thr;
	logic [BOOST_W-1:0]       boost;
	logic [LEVEL_W-1:0]       level;
	logic [LEVEL_W-1:0]       limit;
	logic                     voice;
	logic                     start;
	logic                     rec_now;
	logic [COUNT_BITS-1:0]    fc_b;
	logic [COUNT_BITS-1:0]    sc_b;
	logic [WINDOW_FRAMES-1:0] ring_b;
	logic [SUM_W-1:0]         sum_b;
	logic [SUM_W-1:0]         pcnt_b;
	logic                     old_bit;
	logic [WINDOW_FRAMES-1:0] ring_n;
	logic [SUM_W-1:0]         sum_n;
	logic [SUM_W-1:0]         pcnt_n;
	logic                     full;
	logic [COUNT_BITS-1:0]    fc_n;
	logic [COUNT_BITS-1:0]    sc_n;
	logic [REASON_W-1:0]      reason;
	logic [FRAMES_W-1:0]      shown;

	// voiced when the window is full and rms * 16 > thr * boost, compared exactly
	assign thr   = rec_q ? cfg.continue_threshold : cfg.start_threshold;
	assign boost = (item.playback_active && (cfg.playback_boost > BOOST_UNITY)) ?
	               cfg.playback_boost : BOOST_UNITY;
	assign level = {4'b0000, item.frame_level, 4'b0000};
	assign limit = LEVEL_W'(thr) * LEVEL_W'(boost);
	assign voice = item.win_full && (level > limit);

	assign start   = voice && !rec_q;
	assign rec_now = rec_q || voice;

	// a new recording starts from an empty history
	assign fc_b    = start ? '0 : fc_q;
	assign sc_b    = start ? '0 : sc_q;
	assign ring_b  = start ? '0 : ring_q;
	assign sum_b   = start ? '0 : sum_q;
	assign pcnt_b  = start ? '0 : pcnt_q;
	assign old_bit = ring_b[WINDOW_FRAMES-1];

	// history as a shift line: the bit falling out is the one pushed a window ago
	generate
		if (WINDOW_FRAMES == 1) begin : g_ring_one
			assign ring_n = voice;
		end else begin : g_ring_many
			assign ring_n = {ring_b[WINDOW_FRAMES-2:0], voice};
		end
	endgenerate

	assign sum_n  = sum_b - SUM_W'(old_bit) + SUM_W'(voice);
	assign pcnt_n = (pcnt_b == PUSH_FULL) ? PUSH_FULL : pcnt_b + 1'b1;
	assign full   = (pcnt_n == PUSH_FULL);
	assign fc_n   = (fc_b == COUNT_MAX) ? COUNT_MAX : fc_b + 1'b1;
	assign sc_n   = voice ? '0 : ((sc_b == COUNT_MAX) ? COUNT_MAX : sc_b + 1'b1);

	always_comb begin
		reason = END_NONE;
		if (rec_now) begin
			if ((CMP_W'(fc_n) >= CMP_W'(cfg.min_speech_frames)) &&
			    (CMP_W'(sc_n) >= CMP_W'(cfg.end_silence_frames))) begin
				reason = END_SILENCE;
			end else if ((cfg.min_voiced_in_window != '0) &&
			             (CMP_W'(fc_n) >= CMP_W'(cfg.early_close_min_frames)) && full &&
			             (VCMP_W'(sum_n) < VCMP_W'(cfg.min_voiced_in_window))) begin
				reason = END_LOW_ACT;
			end else if ((cfg.max_frames != '0) &&
			             (CMP_W'(fc_n) >= CMP_W'(cfg.max_frames))) begin
				reason = END_MAX_LEN;
			end
		end
	end

	assign shown = (CMP_W'(fc_n) > CMP_W'(SHOW_MAX)) ? SHOW_MAX : FRAMES_W'(fc_n);

	assign res.voice           = voice;
	assign res.voice_edge      = voice != last_q;
	assign res.recording       = rec_now && (reason == END_NONE);
	assign res.started         = start;
	assign res.end_reason      = reason;
	assign res.frames_recorded = rec_now ? shown : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q  <= 1'b0;
			last_q <= 1'b0;
			fc_q   <= '0;
			sc_q   <= '0;
			ring_q <= '0;
			sum_q  <= '0;
			pcnt_q <= '0;
		end else if (step) begin
			last_q <= voice;
			rec_q  <= rec_now && (reason == END_NONE);
			if (rec_now) begin
				fc_q   <= fc_n;
				sc_q   <= sc_n;
				ring_q <= ring_n;
				sum_q  <= sum_n;
				pcnt_q <= pcnt_n;
			end
		end
	end

	a_sum_le_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= pcnt_q)
		else $error("voiced sum exceeds number of pushes");

	a_silence_le_frames: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= fc_q)
		else $error("silence count exceeds frame count");

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && (reason != END_NONE) |=> !rec_q)
		else $error("recording still active after end");

	a_start_records: assert property (@(posedge clk) disable iff (!arst_n)
		step && start && (reason == END_NONE) |=> rec_q && (fc_q == COUNT_BITS'(1)))
		else $error("started recording not held");

endmodule

// File: src/energy_vad_endpointer.sv
// An accepted request passes the input register and then the result register before
// out_valid rises; while out_stall holds a full result register, in_stall holds the next.
// Throughput: one request per cycle unless out_stall backs up into in_stall; the state
// update in evad_endpoint closes the loop from one frame to the next.
// Reset (arst_n low, asynchronous): idle, counters and voiced history cleared,
// configuration registers at their default values, both stages empty.
module energy_vad_endpointer #(
	parameter int WINDOW_FRAMES = 64,
	parameter int COUNT_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [evad_pkg::RMS_W-1:0]      frame_level,
	input  logic                            win_full,
	input  logic                            playback_active,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            voice,
	output logic                            voice_edge,
	output logic                            recording,
	output logic                            started,
	output logic [evad_pkg::REASON_W-1:0]   end_reason,
	output logic [evad_pkg::FRAMES_W-1:0]   frames_recorded
);
	import evad_pkg::*;

	cfg_t     cfg;
	in_item_t item_s1;
	logic     valid_s1;
	result_t  res;
	result_t  res_s2;
	logic     valid_s2;
	logic     adv_s1;
	logic     step;

	evad_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves on whenever the result register is empty or being drained
	assign adv_s1   = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.frame_level     <= frame_level;
			item_s1.win_full        <= win_full;
			item_s1.playback_active <= playback_active;
		end
	end

	evad_endpoint #(
		.WINDOW_FRAMES (WINDOW_FRAMES),
		.COUNT_BITS    (COUNT_BITS)
	) u_endpoint (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign voice           = res_s2.voice;
	assign voice_edge      = res_s2.voice_edge;
	assign recording       = res_s2.recording;
	assign started         = res_s2.started;
	assign end_reason      = res_s2.end_reason;
	assign frames_recorded = res_s2.frames_recorded;

endmodule
